// File: src/sip_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants, status codes and control word for the intersection pipe.
// ----------------------------------------------------------------------------
package sip_pkg;

  // Default coordinate width
  localparam int unsigned COORD_WIDTH = 16;

  // Slots of the endpoint bundle
  localparam int unsigned NUM_PTS  = 8;
  localparam int unsigned PT_A_SX  = 0;
  localparam int unsigned PT_A_SY  = 1;
  localparam int unsigned PT_A_EX  = 2;
  localparam int unsigned PT_A_EY  = 3;
  localparam int unsigned PT_B_SX  = 4;
  localparam int unsigned PT_B_SY  = 5;
  localparam int unsigned PT_B_EX  = 6;
  localparam int unsigned PT_B_EY  = 7;

  // Slots of the cross product bundle: four orientations and the denominator
  localparam int unsigned NUM_XP   = 5;
  localparam int unsigned XP_O1    = 0;
  localparam int unsigned XP_O2    = 1;
  localparam int unsigned XP_O3    = 2;
  localparam int unsigned XP_O4    = 3;
  localparam int unsigned XP_DEN   = 4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_POINT    = 2'd1,
    ST_PARALLEL = 2'd2
  } status_e;

  // Control word that rides along the multiply and divide stages
  typedef struct packed {
    status_e status;
    logic    use_div;
    logic    neg_x;
    logic    neg_y;
  } ctrl_t;

endpackage

// File: src/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// Segment intersection point
// Crossing point of two line segments from orientation tests, with a
// pipelined exact divide for the crossing position.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Words
//  --------+-----------+---------------------------+-------------------------
//  segment | in        | start high, busy low      | a/b start/end x/y
//  result  | out       | done_o strobe, one cycle  | hit_status, point_x/y
//
//  One word is taken every cycle while busy is low; each result appears once its
//  word has passed the front end, the decision stages, the divider and the result
//  register. The divider resolves one quotient bit per stage.
//  Reset clears all valid bits; busy is high during reset and until the first
//  clock edge after it, and low from then on. Nothing stalls: the result port
//  cannot hold off, and the pipe advances every cycle.
//
module segment_intersection_point #(
  parameter int unsigned COORD_WIDTH = sip_pkg::COORD_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]  b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  b_end_y_i,
  output logic                           done_o,
  output logic [1:0]                     hit_status_o,
  output logic signed [COORD_WIDTH-1:0]  point_x_o,
  output logic signed [COORD_WIDTH-1:0]  point_y_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = $bits(sip_pkg::ctrl_t) + 2 * W;

  logic                                       busy_q;
  logic                                       accept;
  logic [sip_pkg::NUM_PTS-1:0][W-1:0]         pts;

  // Hold busy through reset and its first cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // Bundle the endpoints
  always_comb begin
    pts[sip_pkg::PT_A_SX] = a_start_x_i;
    pts[sip_pkg::PT_A_SY] = a_start_y_i;
    pts[sip_pkg::PT_A_EX] = a_end_x_i;
    pts[sip_pkg::PT_A_EY] = a_end_y_i;
    pts[sip_pkg::PT_B_SX] = b_start_x_i;
    pts[sip_pkg::PT_B_SY] = b_start_y_i;
    pts[sip_pkg::PT_B_EX] = b_end_x_i;
    pts[sip_pkg::PT_B_EY] = b_end_y_i;
  end

  // Front end: differences, box tests, cross products
  logic                                         fr_valid;
  logic [sip_pkg::NUM_PTS-1:0][W-1:0]           fr_pts;
  logic [3:0]                                   fr_box;
  logic signed [W:0]                            fr_dax, fr_day;
  logic [sip_pkg::NUM_XP-1:0][2*W+2:0]          fr_cross;

  sip_front #(
    .COORD_WIDTH (W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pts_i   (pts),
    .valid_o (fr_valid),
    .pts_o   (fr_pts),
    .box_o   (fr_box),
    .dax_o   (fr_dax),
    .day_o   (fr_day),
    .cross_o (fr_cross)
  );

  // Decision and dividend forming
  logic                 dc_valid;
  sip_pkg::ctrl_t       dc_ctrl;
  logic [W-1:0]         dc_base_x, dc_base_y;
  logic [3*W+1:0]       dc_dvd_x, dc_dvd_y;
  logic [2*W+1:0]       dc_dvs;

  sip_decide #(
    .COORD_WIDTH (W)
  ) u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (fr_valid),
    .pts_i    (fr_pts),
    .box_i    (fr_box),
    .dax_i    (fr_dax),
    .day_i    (fr_day),
    .cross_i  (fr_cross),
    .valid_o  (dc_valid),
    .ctrl_o   (dc_ctrl),
    .base_x_o (dc_base_x),
    .base_y_o (dc_base_y),
    .dvd_x_o  (dc_dvd_x),
    .dvd_y_o  (dc_dvd_y),
    .dvs_o    (dc_dvs)
  );

  // Divider with the control word and base point as sideband
  logic                 dv_valid;
  logic [SW-1:0]        dv_side;
  logic [W-1:0]         dv_quo_x, dv_quo_y;
  sip_pkg::ctrl_t       dv_ctrl;
  logic [W-1:0]         dv_base_x, dv_base_y;

  sip_div #(
    .COORD_WIDTH (W),
    .SIDE_WIDTH  (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dc_valid),
    .side_i  ({dc_ctrl, dc_base_x, dc_base_y}),
    .dvd_x_i (dc_dvd_x),
    .dvd_y_i (dc_dvd_y),
    .dvs_i   (dc_dvs),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_x_o (dv_quo_x),
    .quo_y_o (dv_quo_y)
  );

  assign {dv_ctrl, dv_base_x, dv_base_y} = dv_side;

  // Apply the signed offset to the base point
  logic [W-1:0] point_x_d, point_y_d;

  always_comb begin
    point_x_d = dv_base_x;
    point_y_d = dv_base_y;
    if (dv_ctrl.use_div) begin
      point_x_d = dv_ctrl.neg_x ? (dv_base_x - dv_quo_x) : (dv_base_x + dv_quo_x);
      point_y_d = dv_ctrl.neg_y ? (dv_base_y - dv_quo_y) : (dv_base_y + dv_quo_y);
    end
  end

  logic                 done_q;
  sip_pkg::status_e     status_q;
  logic [W-1:0]         point_x_q, point_y_q;

  // Register the result word
  always_ff @(posedge clk_i) begin
    if (dv_valid) begin
      status_q  <= dv_ctrl.status;
      point_x_q <= point_x_d;
      point_y_q <= point_y_d;
    end
  end

  // Strobe for one cycle per result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  assign done_o       = done_q;
  assign hit_status_o = status_q;
  assign point_x_o    = $signed(point_x_q);
  assign point_y_o    = $signed(point_y_q);

endmodule

// File: src/sip_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Three stages: coordinate differences and box tests, cross product
// multiplies, cross product subtracts.
// ----------------------------------------------------------------------------
module sip_front #(
  parameter int unsigned COORD_WIDTH = sip_pkg::COORD_WIDTH
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  input  logic [sip_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0]        pts_i,
  output logic                                                valid_o,
  output logic [sip_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0]        pts_o,
  output logic [3:0]                                          box_o,
  output logic signed [COORD_WIDTH:0]                         dax_o,
  output logic signed [COORD_WIDTH:0]                         day_o,
  output logic [sip_pkg::NUM_XP-1:0][2*COORD_WIDTH+2:0]       cross_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DW  = W + 1;
  localparam int unsigned PRW = 2 * DW;
  localparam int unsigned CW  = PRW + 1;
  localparam int unsigned NXP = sip_pkg::NUM_XP;
  localparam int unsigned NPT = sip_pkg::NUM_PTS;

  // True when (vx, vy) lies in the box spanned by (sx, sy) and (ex, ey)
  function automatic logic in_box(input logic signed [W-1:0] sx, input logic signed [W-1:0] sy,
                                  input logic signed [W-1:0] ex, input logic signed [W-1:0] ey,
                                  input logic signed [W-1:0] vx, input logic signed [W-1:0] vy);
    logic in_x;
    logic in_y;
    in_x = (vx <= sx || vx <= ex) && (vx >= sx || vx >= ex);
    in_y = (vy <= sy || vy <= ey) && (vy >= sy || vy >= ey);
    return in_x && in_y;
  endfunction

  logic signed [W-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;

  assign asx = $signed(pts_i[sip_pkg::PT_A_SX]);
  assign asy = $signed(pts_i[sip_pkg::PT_A_SY]);
  assign aex = $signed(pts_i[sip_pkg::PT_A_EX]);
  assign aey = $signed(pts_i[sip_pkg::PT_A_EY]);
  assign bsx = $signed(pts_i[sip_pkg::PT_B_SX]);
  assign bsy = $signed(pts_i[sip_pkg::PT_B_SY]);
  assign bex = $signed(pts_i[sip_pkg::PT_B_EX]);
  assign bey = $signed(pts_i[sip_pkg::PT_B_EY]);

  // ---- Stage A: differences and box tests ----
  logic                          va_q;
  logic [NPT-1:0][W-1:0]         pts_a_q;
  logic [3:0]                    box_a_q;
  logic signed [DW-1:0]          dax_q, day_q, dbx_q, dby_q;
  logic signed [DW-1:0]          pbx_q, pby_q, pex_q, pey_q;
  logic signed [DW-1:0]          qax_q, qay_q, qex_q, qey_q;

  // Capture endpoints, box tests and differences for accepted words
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pts_a_q    <= pts_i;
      box_a_q[0] <= in_box(asx, asy, aex, aey, bsx, bsy);
      box_a_q[1] <= in_box(asx, asy, aex, aey, bex, bey);
      box_a_q[2] <= in_box(bsx, bsy, bex, bey, asx, asy);
      box_a_q[3] <= in_box(bsx, bsy, bex, bey, aex, aey);
      dax_q      <= DW'(aex) - DW'(asx);
      day_q      <= DW'(aey) - DW'(asy);
      dbx_q      <= DW'(bex) - DW'(bsx);
      dby_q      <= DW'(bey) - DW'(bsy);
      pbx_q      <= DW'(bsx) - DW'(asx);
      pby_q      <= DW'(bsy) - DW'(asy);
      pex_q      <= DW'(bex) - DW'(asx);
      pey_q      <= DW'(bey) - DW'(asy);
      qax_q      <= DW'(asx) - DW'(bsx);
      qay_q      <= DW'(asy) - DW'(bsy);
      qex_q      <= DW'(aex) - DW'(bsx);
      qey_q      <= DW'(aey) - DW'(bsy);
    end
  end

  // ---- Stage B: cross product multiplies ----
  logic signed [DW-1:0]  ux [NXP];
  logic signed [DW-1:0]  uy [NXP];
  logic signed [DW-1:0]  vx [NXP];
  logic signed [DW-1:0]  vy [NXP];

  // Route operand pairs for each cross product
  always_comb begin
    ux[sip_pkg::XP_O1]  = dax_q;  uy[sip_pkg::XP_O1]  = day_q;
    vx[sip_pkg::XP_O1]  = pbx_q;  vy[sip_pkg::XP_O1]  = pby_q;
    ux[sip_pkg::XP_O2]  = dax_q;  uy[sip_pkg::XP_O2]  = day_q;
    vx[sip_pkg::XP_O2]  = pex_q;  vy[sip_pkg::XP_O2]  = pey_q;
    ux[sip_pkg::XP_O3]  = dbx_q;  uy[sip_pkg::XP_O3]  = dby_q;
    vx[sip_pkg::XP_O3]  = qax_q;  vy[sip_pkg::XP_O3]  = qay_q;
    ux[sip_pkg::XP_O4]  = dbx_q;  uy[sip_pkg::XP_O4]  = dby_q;
    vx[sip_pkg::XP_O4]  = qex_q;  vy[sip_pkg::XP_O4]  = qey_q;
    ux[sip_pkg::XP_DEN] = dax_q;  uy[sip_pkg::XP_DEN] = day_q;
    vx[sip_pkg::XP_DEN] = dbx_q;  vy[sip_pkg::XP_DEN] = dby_q;
  end

  logic                      vb_q;
  logic [NPT-1:0][W-1:0]     pts_b_q;
  logic [3:0]                box_b_q;
  logic signed [DW-1:0]      dax_b_q, day_b_q;
  logic signed [PRW-1:0]     prod_a_q [NXP];
  logic signed [PRW-1:0]     prod_b_q [NXP];

  // Form both partial products of every cross product
  always_ff @(posedge clk_i) begin
    if (va_q) begin
      pts_b_q <= pts_a_q;
      box_b_q <= box_a_q;
      dax_b_q <= dax_q;
      day_b_q <= day_q;
      for (int k = 0; k < NXP; k++) begin
        prod_a_q[k] <= PRW'(ux[k]) * PRW'(vy[k]);
        prod_b_q[k] <= PRW'(uy[k]) * PRW'(vx[k]);
      end
    end
  end

  // ---- Stage C: cross product subtracts ----
  logic                      vc_q;
  logic [NPT-1:0][W-1:0]     pts_c_q;
  logic [3:0]                box_c_q;
  logic signed [DW-1:0]      dax_c_q, day_c_q;
  logic [NXP-1:0][CW-1:0]    cross_c_q;

  // Finish the cross products
  always_ff @(posedge clk_i) begin
    if (vb_q) begin
      pts_c_q <= pts_b_q;
      box_c_q <= box_b_q;
      dax_c_q <= dax_b_q;
      day_c_q <= day_b_q;
      for (int k = 0; k < NXP; k++) begin
        cross_c_q[k] <= CW'(prod_a_q[k]) - CW'(prod_b_q[k]);
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign valid_o = vc_q;
  assign pts_o   = pts_c_q;
  assign box_o   = box_c_q;
  assign dax_o   = dax_c_q;
  assign day_o   = day_c_q;
  assign cross_o = cross_c_q;

endmodule

// File: src/sip_decide.sv
// ----------------------------------------------------------------------------
// Segment intersection decision and scaling
// Three stages: orientation decision and magnitudes, split multiplies of the
// direction by the numerator, partial product sum into the dividend.
// ----------------------------------------------------------------------------
module sip_decide #(
  parameter int unsigned COORD_WIDTH = sip_pkg::COORD_WIDTH
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  input  logic [sip_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0]        pts_i,
  input  logic [3:0]                                          box_i,
  input  logic signed [COORD_WIDTH:0]                         dax_i,
  input  logic signed [COORD_WIDTH:0]                         day_i,
  input  logic [sip_pkg::NUM_XP-1:0][2*COORD_WIDTH+2:0]       cross_i,
  output logic                                                valid_o,
  output sip_pkg::ctrl_t                                      ctrl_o,
  output logic [COORD_WIDTH-1:0]                              base_x_o,
  output logic [COORD_WIDTH-1:0]                              base_y_o,
  output logic [3*COORD_WIDTH+1:0]                            dvd_x_o,
  output logic [3*COORD_WIDTH+1:0]                            dvd_y_o,
  output logic [2*COORD_WIDTH+1:0]                            dvs_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DW  = W + 1;
  localparam int unsigned CW  = 2 * W + 3;
  localparam int unsigned MW  = CW - 1;
  localparam int unsigned H   = W + 1;
  localparam int unsigned PPW = W + H;
  localparam int unsigned PW  = W + MW;

  // ---- Stage D: decide the case and take magnitudes ----
  logic [3:0]          zero;
  logic [3:0]          neg;
  logic                den_zero;
  logic                crossing;
  logic [CW-1:0]       num;
  logic [CW-1:0]       den;
  logic [CW-1:0]       num_abs;
  logic [CW-1:0]       den_abs;
  logic [DW-1:0]       ax_abs;
  logic [DW-1:0]       ay_abs;
  sip_pkg::ctrl_t      ctrl_d;
  logic [W-1:0]        base_x_d;
  logic [W-1:0]        base_y_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      zero[k] = (cross_i[k] == '0);
      neg[k]  = cross_i[k][CW-1];
    end
    num      = cross_i[sip_pkg::XP_O3];
    den      = cross_i[sip_pkg::XP_DEN];
    den_zero = (den == '0);
    crossing = ((zero[0] != zero[1]) || (neg[0] != neg[1])) &&
               ((zero[2] != zero[3]) || (neg[2] != neg[3]));
    num_abs  = num[CW-1] ? (~num + 1'b1) : num;
    den_abs  = den[CW-1] ? (~den + 1'b1) : den;
    ax_abs   = dax_i[DW-1] ? DW'(-dax_i) : DW'(dax_i);
    ay_abs   = day_i[DW-1] ? DW'(-day_i) : DW'(day_i);

    ctrl_d.status  = sip_pkg::ST_NONE;
    ctrl_d.use_div = 1'b0;
    ctrl_d.neg_x   = dax_i[DW-1] ^ num[CW-1] ^ den[CW-1];
    ctrl_d.neg_y   = day_i[DW-1] ^ num[CW-1] ^ den[CW-1];
    base_x_d       = '0;
    base_y_d       = '0;

    // Proper crossing first, then collinear endpoints in priority order
    if (crossing) begin
      if (den_zero) begin
        ctrl_d.status = sip_pkg::ST_PARALLEL;
      end else begin
        ctrl_d.status  = sip_pkg::ST_POINT;
        ctrl_d.use_div = 1'b1;
        base_x_d       = pts_i[sip_pkg::PT_A_SX];
        base_y_d       = pts_i[sip_pkg::PT_A_SY];
      end
    end else if (zero[0] && box_i[0]) begin
      ctrl_d.status = sip_pkg::ST_POINT;
      base_x_d      = pts_i[sip_pkg::PT_B_SX];
      base_y_d      = pts_i[sip_pkg::PT_B_SY];
    end else if (zero[1] && box_i[1]) begin
      ctrl_d.status = sip_pkg::ST_POINT;
      base_x_d      = pts_i[sip_pkg::PT_B_EX];
      base_y_d      = pts_i[sip_pkg::PT_B_EY];
    end else if (zero[2] && box_i[2]) begin
      ctrl_d.status = sip_pkg::ST_POINT;
      base_x_d      = pts_i[sip_pkg::PT_A_SX];
      base_y_d      = pts_i[sip_pkg::PT_A_SY];
    end else if (zero[3] && box_i[3]) begin
      ctrl_d.status = sip_pkg::ST_POINT;
      base_x_d      = pts_i[sip_pkg::PT_A_EX];
      base_y_d      = pts_i[sip_pkg::PT_A_EY];
    end
  end

  logic             vd_q;
  sip_pkg::ctrl_t   ctrl_dq;
  logic [W-1:0]     base_x_dq, base_y_dq;
  logic [MW-1:0]    mag_num_q, mag_den_q;
  logic [W-1:0]     mag_ax_q, mag_ay_q;

  // Hold the decision and magnitudes
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ctrl_dq   <= ctrl_d;
      base_x_dq <= base_x_d;
      base_y_dq <= base_y_d;
      mag_num_q <= num_abs[MW-1:0];
      mag_den_q <= den_abs[MW-1:0];
      mag_ax_q  <= ax_abs[W-1:0];
      mag_ay_q  <= ay_abs[W-1:0];
    end
  end

  // ---- Stage E: split multiplies ----
  logic             ve_q;
  sip_pkg::ctrl_t   ctrl_eq;
  logic [W-1:0]     base_x_eq, base_y_eq;
  logic [MW-1:0]    den_eq;
  logic [PPW-1:0]   pp_xl_q, pp_xh_q, pp_yl_q, pp_yh_q;

  // Multiply each direction by both halves of the numerator
  always_ff @(posedge clk_i) begin
    if (vd_q) begin
      ctrl_eq   <= ctrl_dq;
      base_x_eq <= base_x_dq;
      base_y_eq <= base_y_dq;
      den_eq    <= mag_den_q;
      pp_xl_q   <= PPW'(mag_ax_q) * PPW'(mag_num_q[H-1:0]);
      pp_xh_q   <= PPW'(mag_ax_q) * PPW'(mag_num_q[MW-1:H]);
      pp_yl_q   <= PPW'(mag_ay_q) * PPW'(mag_num_q[H-1:0]);
      pp_yh_q   <= PPW'(mag_ay_q) * PPW'(mag_num_q[MW-1:H]);
    end
  end

  // ---- Stage F: dividend assembly ----
  logic             vf_q;
  sip_pkg::ctrl_t   ctrl_fq;
  logic [W-1:0]     base_x_fq, base_y_fq;
  logic [MW-1:0]    den_fq;
  logic [PW-1:0]    dvd_x_q, dvd_y_q;

  // Sum the shifted partial products
  always_ff @(posedge clk_i) begin
    if (ve_q) begin
      ctrl_fq   <= ctrl_eq;
      base_x_fq <= base_x_eq;
      base_y_fq <= base_y_eq;
      den_fq    <= den_eq;
      dvd_x_q   <= {pp_xh_q, {H{1'b0}}} + PW'(pp_xl_q);
      dvd_y_q   <= {pp_yh_q, {H{1'b0}}} + PW'(pp_yl_q);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      vd_q <= valid_i;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  assign valid_o  = vf_q;
  assign ctrl_o   = ctrl_fq;
  assign base_x_o = base_x_fq;
  assign base_y_o = base_y_fq;
  assign dvd_x_o  = dvd_x_q;
  assign dvd_y_o  = dvd_y_q;
  assign dvs_o    = den_fq;

endmodule

// File: src/sip_div.sv
// ----------------------------------------------------------------------------
// Segment intersection divider
// Pipelined restoring divider, one quotient bit per stage, two dividends over
// a shared divisor, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module sip_div #(
  parameter int unsigned COORD_WIDTH = sip_pkg::COORD_WIDTH,
  parameter int unsigned SIDE_WIDTH  = $bits(sip_pkg::ctrl_t) + 2 * COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [SIDE_WIDTH-1:0]         side_i,
  input  logic [3*COORD_WIDTH+1:0]      dvd_x_i,
  input  logic [3*COORD_WIDTH+1:0]      dvd_y_i,
  input  logic [2*COORD_WIDTH+1:0]      dvs_i,
  output logic                          valid_o,
  output logic [SIDE_WIDTH-1:0]         side_o,
  output logic [COORD_WIDTH-1:0]        quo_x_o,
  output logic [COORD_WIDTH-1:0]        quo_y_o
);

  localparam int unsigned QW = COORD_WIDTH;
  localparam int unsigned MW = 2 * COORD_WIDTH + 2;

  // Stage registers; remainder and divisor are not needed after the last step
  logic                   vld_q  [1:QW];
  logic [SIDE_WIDTH-1:0]  side_q [1:QW];
  logic [QW-1:0]          low_x_q [1:QW];
  logic [QW-1:0]          low_y_q [1:QW];
  logic [MW-1:0]          rem_x_q [1:QW-1];
  logic [MW-1:0]          rem_y_q [1:QW-1];
  logic [MW-1:0]          dvs_q   [1:QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic                   vld_s;
    logic [SIDE_WIDTH-1:0]  side_s;
    logic [QW-1:0]          low_x_s, low_y_s;
    logic [MW-1:0]          rem_x_s, rem_y_s, dvs_s;
    logic [MW:0]            tx, ty, dv, dfx, dfy;
    logic                   gex, gey;

    // Select this step's source: the inputs or the previous stage
    if (i == 0) begin : g_src_in
      assign vld_s   = valid_i;
      assign side_s  = side_i;
      assign rem_x_s = dvd_x_i[3*COORD_WIDTH+1:QW];
      assign rem_y_s = dvd_y_i[3*COORD_WIDTH+1:QW];
      assign low_x_s = dvd_x_i[QW-1:0];
      assign low_y_s = dvd_y_i[QW-1:0];
      assign dvs_s   = dvs_i;
    end else begin : g_src_reg
      assign vld_s   = vld_q[i];
      assign side_s  = side_q[i];
      assign rem_x_s = rem_x_q[i];
      assign rem_y_s = rem_y_q[i];
      assign low_x_s = low_x_q[i];
      assign low_y_s = low_y_q[i];
      assign dvs_s   = dvs_q[i];
    end

    // Shift in the next dividend bit and trial-subtract the divisor
    assign dv  = {1'b0, dvs_s};
    assign tx  = {rem_x_s, low_x_s[QW-1]};
    assign ty  = {rem_y_s, low_y_s[QW-1]};
    assign dfx = tx - dv;
    assign dfy = ty - dv;
    assign gex = (tx >= dv);
    assign gey = (ty >= dv);

    always_ff @(posedge clk_i) begin
      if (vld_s) begin
        side_q[i+1]  <= side_s;
        low_x_q[i+1] <= {low_x_s[QW-2:0], gex};
        low_y_q[i+1] <= {low_y_s[QW-2:0], gey};
      end
    end

    if (i < QW - 1) begin : g_rem
      // Keep the partial remainder for the next step
      always_ff @(posedge clk_i) begin
        if (vld_s) begin
          rem_x_q[i+1] <= gex ? dfx[MW-1:0] : tx[MW-1:0];
          rem_y_q[i+1] <= gey ? dfy[MW-1:0] : ty[MW-1:0];
          dvs_q[i+1]   <= dvs_s;
        end
      end
    end

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_s;
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];
  assign quo_x_o = low_x_q[QW];
  assign quo_y_o = low_y_q[QW];

endmodule

// File: src/sip_checker.sv
// ----------------------------------------------------------------------------
// Segment intersection port checker
// Watches the top level ports for latency, result coding and a known-answer
// case, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module sip_checker #(
  parameter int unsigned COORD_WIDTH = sip_pkg::COORD_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic signed [COORD_WIDTH-1:0]  a_start_x_i,
  input logic signed [COORD_WIDTH-1:0]  a_start_y_i,
  input logic signed [COORD_WIDTH-1:0]  b_start_x_i,
  input logic signed [COORD_WIDTH-1:0]  b_start_y_i,
  input logic                           done_o,
  input logic [1:0]                     hit_status_o,
  input logic signed [COORD_WIDTH-1:0]  point_x_o,
  input logic signed [COORD_WIDTH-1:0]  point_y_o
);

  localparam int unsigned LAT = COORD_WIDTH + 7;

  logic accept;
  logic same_start;

  assign accept     = start && !busy;
  assign same_start = accept && (a_start_x_i == b_start_x_i) &&
                      (a_start_y_i == b_start_y_i);

  // Every taken word gives exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept, LAT))
    else $error("result strobe does not match a taken word");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_status_o == sip_pkg::ST_NONE || hit_status_o == sip_pkg::ST_POINT ||
                hit_status_o == sip_pkg::ST_PARALLEL))
    else $error("undefined status code on the result port");

  // Point is zero unless a point is reported
  a_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_status_o != sip_pkg::ST_POINT) |-> (point_x_o == '0 && point_y_o == '0))
    else $error("nonzero point without a valid hit");

  // Segments sharing a start point meet at that point
  a_shared_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(same_start, LAT) |-> (done_o && hit_status_o == sip_pkg::ST_POINT &&
                                point_x_o == $past(a_start_x_i, LAT) &&
                                point_y_o == $past(a_start_y_i, LAT)))
    else $error("shared start point not reported");

endmodule

bind segment_intersection_point sip_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_sip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .a_start_x_i  (a_start_x_i),
  .a_start_y_i  (a_start_y_i),
  .b_start_x_i  (b_start_x_i),
  .b_start_y_i  (b_start_y_i),
  .done_o       (done_o),
  .hit_status_o (hit_status_o),
  .point_x_o    (point_x_o),
  .point_y_o    (point_y_o)
);

// File: sim/segment_crossing_checker.sv
// ----------------------------------------------------------------------------
// Segment crossing checker
// Watches the segment and result channels of the intersection block, predicts
// the status and crossing point of every accepted word and compares each
// result strobe with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_crossing_checker #(
  parameter int unsigned COORD_WIDTH = sip_pkg::COORD_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic signed [COORD_WIDTH-1:0]  a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]  b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  b_end_y_i,
  input  logic                           done_i,
  input  logic [1:0]                     hit_status_i,
  input  logic signed [COORD_WIDTH-1:0]  point_x_i,
  input  logic signed [COORD_WIDTH-1:0]  point_y_i,
  input  logic                           end_i,
  output int                             pending_o,
  output int                             err_count_o
);

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  typedef struct {
    sip_pkg::status_e                status;
    logic signed [COORD_WIDTH-1:0]   x;
    logic signed [COORD_WIDTH-1:0]   y;
  } hit_t;

  hit_t hits_q[$];
  int   err_count = 0;
  int   result_idx = 0;

  function automatic longint cross_prod(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  // Side of r relative to the directed line p -> q
  function automatic int turn(pt_t p, pt_t q, pt_t r);
    longint c;
    c = cross_prod(q.x - p.x, q.y - p.y, r.x - p.x, r.y - p.y);
    return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
  endfunction

  function automatic bit in_box(pt_t s, pt_t e, pt_t v);
    longint lo_x, hi_x, lo_y, hi_y;
    lo_x = (s.x < e.x) ? s.x : e.x;
    hi_x = (s.x > e.x) ? s.x : e.x;
    lo_y = (s.y < e.y) ? s.y : e.y;
    hi_y = (s.y > e.y) ? s.y : e.y;
    return v.x >= lo_x && v.x <= hi_x && v.y >= lo_y && v.y <= hi_y;
  endfunction

  function automatic hit_t make_hit(sip_pkg::status_e st, longint x, longint y);
    hit_t h;
    h.status = st;
    h.x      = x[COORD_WIDTH-1:0];
    h.y      = y[COORD_WIDTH-1:0];
    return h;
  endfunction

  // Expected status and point for one pair of segments, exact integer math
  function automatic hit_t crossing_point(pt_t as, pt_t ae, pt_t bs, pt_t be);
    int     o1, o2, o3, o4;
    longint dax, day, dbx, dby, den, num;
    o1 = turn(as, ae, bs);
    o2 = turn(as, ae, be);
    o3 = turn(bs, be, as);
    o4 = turn(bs, be, ae);
    if (o1 != o2 && o3 != o4) begin
      dax = ae.x - as.x;
      day = ae.y - as.y;
      dbx = be.x - bs.x;
      dby = be.y - bs.y;
      den = cross_prod(dax, day, dbx, dby);
      if (den == 0) return make_hit(sip_pkg::ST_PARALLEL, 0, 0);
      num = cross_prod(bs.x - as.x, bs.y - as.y, dbx, dby);
      return make_hit(sip_pkg::ST_POINT, as.x + (dax * num) / den, as.y + (day * num) / den);
    end
    // Touching or collinear: first matching endpoint wins
    if (o1 == 0 && in_box(as, ae, bs)) return make_hit(sip_pkg::ST_POINT, bs.x, bs.y);
    if (o2 == 0 && in_box(as, ae, be)) return make_hit(sip_pkg::ST_POINT, be.x, be.y);
    if (o3 == 0 && in_box(bs, be, as)) return make_hit(sip_pkg::ST_POINT, as.x, as.y);
    if (o4 == 0 && in_box(bs, be, ae)) return make_hit(sip_pkg::ST_POINT, ae.x, ae.y);
    return make_hit(sip_pkg::ST_NONE, 0, 0);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  // Predict on each accepted word, compare on each result strobe
  always @(posedge clk_i) begin
    hit_t want;
    pt_t  as, ae, bs, be;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        as.x = a_start_x_i;  as.y = a_start_y_i;
        ae.x = a_end_x_i;    ae.y = a_end_y_i;
        bs.x = b_start_x_i;  bs.y = b_start_y_i;
        be.x = b_end_x_i;    be.y = b_end_y_i;
        hits_q.push_back(crossing_point(as, ae, bs, be));
      end
      if (done_i) begin
        if (hits_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no word pending", result_idx));
        end else begin
          want = hits_q.pop_front();
          if (hit_status_i !== want.status)
            report_mismatch($sformatf("result %0d: hit_status %0d, want %0d",
                                      result_idx, hit_status_i, want.status));
          if (point_x_i !== want.x)
            report_mismatch($sformatf("result %0d: point_x %0d, want %0d",
                                      result_idx, point_x_i, want.x));
          if (point_y_i !== want.y)
            report_mismatch($sformatf("result %0d: point_y %0d, want %0d",
                                      result_idx, point_y_i, want.y));
        end
        result_idx++;
      end
      // Flag results that never came
      if (end_i && hits_q.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", hits_q.size()));
        hits_q.delete();
      end
    end
    pending_o   <= hits_q.size();
    err_count_o <= err_count;
  end

endmodule

// File: sim/segment_intersection_point_tb.sv
// ----------------------------------------------------------------------------
// Segment intersection point testbench
// Drives directed and random segment pairs (crossings, collinear overlaps,
// shared endpoints, point segments, full-range extremes), the random ones in phases
// set by a table of sender idle rates; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_point_tb;

  localparam int unsigned W     = sip_pkg::COORD_WIDTH;
  localparam int          MIN_C = -(1 << (W - 1));
  localparam int          MAX_C = (1 << (W - 1)) - 1;
  localparam int          PHASE_WORDS = 175;

  typedef struct {
    int asx, asy, aex, aey, bsx, bsy, bex, bey;
  } seg_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [W-1:0]  a_start_x = '0;
  logic signed [W-1:0]  a_start_y = '0;
  logic signed [W-1:0]  a_end_x = '0;
  logic signed [W-1:0]  a_end_y = '0;
  logic signed [W-1:0]  b_start_x = '0;
  logic signed [W-1:0]  b_start_y = '0;
  logic signed [W-1:0]  b_end_x = '0;
  logic signed [W-1:0]  b_end_y = '0;
  logic                 done;
  logic [1:0]           hit_status;
  logic signed [W-1:0]  point_x;
  logic signed [W-1:0]  point_y;
  logic                 end_flag = 1'b0;
  int                   pending;
  int                   err_count;
  int                   idle_pct = 0;
  int                   phase_idle[4] = '{0, 74, 20, 0};

  segment_intersection_point #(
    .COORD_WIDTH (W)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .a_start_x_i  (a_start_x),
    .a_start_y_i  (a_start_y),
    .a_end_x_i    (a_end_x),
    .a_end_y_i    (a_end_y),
    .b_start_x_i  (b_start_x),
    .b_start_y_i  (b_start_y),
    .b_end_x_i    (b_end_x),
    .b_end_y_i    (b_end_y),
    .done_o       (done),
    .hit_status_o (hit_status),
    .point_x_o    (point_x),
    .point_y_o    (point_y)
  );

  segment_crossing_checker #(
    .COORD_WIDTH (W)
  ) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .a_start_x_i  (a_start_x),
    .a_start_y_i  (a_start_y),
    .a_end_x_i    (a_end_x),
    .a_end_y_i    (a_end_y),
    .b_start_x_i  (b_start_x),
    .b_start_y_i  (b_start_y),
    .b_end_x_i    (b_end_x),
    .b_end_y_i    (b_end_y),
    .done_i       (done),
    .hit_status_i (hit_status),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .end_i        (end_flag),
    .pending_o    (pending),
    .err_count_o  (err_count)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Full-range coordinate, pinned to an extreme now and then
  function automatic int coord_any();
    case ($urandom_range(15))
      0: return MIN_C;
      1: return MAX_C;
      default: return pick(MIN_C, MAX_C);
    endcase
  endfunction

  // One random pair, mostly shaped to reach crossings and endpoint cases
  function automatic seg_t random_pair();
    seg_t s;
    int   kind, px, py, dx, dy;
    kind = $urandom_range(99);
    if (kind < 20) begin
      s.asx = coord_any(); s.asy = coord_any(); s.aex = coord_any(); s.aey = coord_any();
      s.bsx = coord_any(); s.bsy = coord_any(); s.bex = coord_any(); s.bey = coord_any();
    end else if (kind < 40) begin
      // small grid around a random origin: many collinear and touching pairs
      px = pick(-30000, 30000);
      py = pick(-30000, 30000);
      s.asx = px + pick(-6, 6); s.asy = py + pick(-6, 6);
      s.aex = px + pick(-6, 6); s.aey = py + pick(-6, 6);
      s.bsx = px + pick(-6, 6); s.bsy = py + pick(-6, 6);
      s.bex = px + pick(-6, 6); s.bey = py + pick(-6, 6);
    end else if (kind < 70) begin
      // B passes through a point on A
      s.asx = pick(-16000, 16000); s.asy = pick(-16000, 16000);
      s.aex = pick(-16000, 16000); s.aey = pick(-16000, 16000);
      dx = pick(1, 15);
      px = s.asx + (s.aex - s.asx) * dx / 16;
      py = s.asy + (s.aey - s.asy) * dx / 16;
      dx = pick(-16000, 16000);
      dy = pick(-16000, 16000);
      s.bsx = px + dx;            s.bsy = py + dy;
      s.bex = px - dx / pick(1, 3); s.bey = py - dy / pick(1, 3);
    end else if (kind < 88) begin
      // both segments on one line
      px = pick(-30000, 30000);
      py = pick(-30000, 30000);
      dx = pick(-100, 100);
      dy = pick(-100, 100);
      s.asx = px + dx * pick(-10, 10); s.asy = 0;
      s.asy = py + (s.asx - px == 0 ? 0 : 0);
      dx = (dx == 0 && dy == 0) ? 1 : dx;
      begin
        int t1, t2, t3, t4;
        t1 = pick(-10, 10); t2 = pick(-10, 10); t3 = pick(-10, 10); t4 = pick(-10, 10);
        s.asx = px + dx * t1; s.asy = py + dy * t1;
        s.aex = px + dx * t2; s.aey = py + dy * t2;
        s.bsx = px + dx * t3; s.bsy = py + dy * t3;
        s.bex = px + dx * t4; s.bey = py + dy * t4;
      end
    end else begin
      // shared endpoints and point segments
      s.asx = pick(-20000, 20000); s.asy = pick(-20000, 20000);
      s.aex = pick(-20000, 20000); s.aey = pick(-20000, 20000);
      s.bsx = pick(-20000, 20000); s.bsy = pick(-20000, 20000);
      s.bex = pick(-20000, 20000); s.bey = pick(-20000, 20000);
      case ($urandom_range(3))
        0: begin s.bsx = s.aex; s.bsy = s.aey; end
        1: begin s.bex = s.asx; s.bey = s.asy; end
        2: begin s.aex = s.asx; s.aey = s.asy; end
        default: begin
          dx = pick(-5000, 5000);
          dy = pick(-5000, 5000);
          s.aex = s.asx + 2 * dx;  s.aey = s.asy + 2 * dy;
          s.bsx = s.asx + dx;      s.bsy = s.asy + dy;
          s.bex = s.bsx;           s.bey = s.bsy;
        end
      endcase
    end
    return s;
  endfunction

  // Idle per the current rate, then hold the word until it is taken
  task automatic send_pair(input int asx, input int asy, input int aex, input int aey,
                           input int bsx, input int bsy, input int bex, input int bey);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    a_start_x <= W'(asx);
    a_start_y <= W'(asy);
    a_end_x   <= W'(aex);
    a_end_y   <= W'(aey);
    b_start_x <= W'(bsx);
    b_start_y <= W'(bsy);
    b_end_x   <= W'(bex);
    b_end_y   <= W'(bey);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Pause the sender until every predicted result has come back or a guard runs out
  task automatic drain_results();
    int guard;
    start <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 500) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    seg_t s;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: crossings, extremes, endpoint cases, misses
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);
    send_pair(-7, -3, 5, 2, -4, 4, 1, -6);
    send_pair(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C);
    send_pair(MAX_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C);
    send_pair(MIN_C, 0, MAX_C, 0, 0, MIN_C, 0, MAX_C);
    send_pair(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C);
    send_pair(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
    send_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
    send_pair(0, 0, 10, 0, 5, 0, 20, 0);
    send_pair(0, 0, 10, 0, -5, 0, 3, 0);
    send_pair(3, 0, 5, 0, 0, 0, 10, 0);
    send_pair(-5, 0, 3, 0, 0, 0, 10, 0);
    send_pair(5, 10, 5, 0, 0, 0, 10, 0);
    send_pair(5, 0, 5, 10, 0, 0, 10, 0);
    send_pair(0, 0, 10, 0, 0, 5, 10, 5);
    send_pair(0, 0, 3, 3, 5, 5, 9, 9);
    send_pair(0, 0, 1, 1, 10, 0, 20, 5);
    send_pair(0, 0, 4, 4, 4, 4, 8, 0);
    send_pair(2, 2, 2, 2, 0, 0, 4, 4);
    send_pair(1, 2, 1, 2, 3, 4, 3, 4);
    send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
    send_pair(MIN_C, -32767, MAX_C, MAX_C, -32767, MIN_C, MAX_C, 32766);
    send_pair(-1, 0, 0, -1, 0, 0, -1, -1);
    drain_results();

    // Random words, one phase per entry of the sender idle rate table
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (PHASE_WORDS) begin
        s = random_pair();
        send_pair(s.asx, s.asy, s.aex, s.aey, s.bsx, s.bsy, s.bex, s.bey);
      end
      drain_results();
    end

    // Let the pipe empty, then flag anything still owed
    repeat (40) @(posedge clk);
    end_flag <= 1'b1;
    @(posedge clk);
    end_flag <= 1'b0;
    @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
src/sip_pkg.sv
src/sip_front.sv
src/sip_decide.sv
src/sip_div.sv
src/segment_intersection_point.sv
src/sip_checker.sv
sim/segment_crossing_checker.sv
sim/segment_intersection_point_tb.sv
